@@ sv/etp_pkg.sv @@
package etp_pkg;

   localparam int NUM_FUNCS = 16;
   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
   localparam int TOT_IW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int DUMP_LIMIT = (NUM_FUNCS < 16) ? NUM_FUNCS : 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [4:0] FCOUNT_RESET = 5'd16;

   localparam logic KIND_ENTER = 1'b0;
   localparam logic KIND_EXIT = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [3:0]  func_id;
      logic [31:0] timestamp;
      logic        last_event;
   } req_type;

   typedef struct packed {
      logic [3:0]  result_id;
      logic [31:0] total_time;
      logic        malformed;
      logic        last;
   } rsp_type;

   // Decoded event between the front and back parts. For an exit the base
   // time already carries the plus one, so both kinds credit base minus start.
   typedef struct packed {
      logic        is_exit;
      logic [3:0]  func_id;
      logic [32:0] base_time;
      logic        last_event;
   } event_type;

   typedef struct packed {
      logic [3:0]  id;
      logic [31:0] start;
   } stack_entry_type;

endpackage

@@ sv/exclusive_time_profiler.sv @@
// Channel   Ports                              Transaction when
// input     req_push, req_full, req_data       req_push high, req_full low
// result    rsp_empty, rsp_pop, rsp_data       rsp_pop high, rsp_empty low
// config    csr_valid, csr_ready, csr_data     csr_valid and csr_ready high
//
// Each enter or exit event in the back unit has a stack step (stack memory access
// and span compute), followed by the saturating totals update.
// An event marked last then emits function_count totals (at least one, at most 16),
// at one total per cycle while rsp_pop keeps up.
// A four-entry event queue ahead of the back unit absorbs short bursts.
// Reset is synchronous; it empties the queues and the stack, clears the totals and
// the error flag, and sets function_count to 16. No clearing pass follows it.
// A result left unpopped stalls the dump; the event queue then fills and raises req_full.
module exclusive_time_profiler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  etp_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output etp_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   logic ev_valid;
   logic ev_pop;
   etp_pkg::event_type ev_data;

   etp_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .ev_valid(ev_valid),
      .ev_pop(ev_pop),
      .ev_data(ev_data)
   );

   etp_back u_back (
      .clock(clock),
      .reset(reset),
      .ev_valid(ev_valid),
      .ev_pop(ev_pop),
      .ev_data(ev_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

endmodule

@@ sv/etp_ram.sv @@
module etp_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/etp_front.sv @@
module etp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  etp_pkg::req_type    req_data,
   output logic                ev_valid,
   input  logic                ev_pop,
   output etp_pkg::event_type  ev_data
);

   etp_pkg::event_type queue_ff [etp_pkg::QUEUE_DEPTH];
   logic [etp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [etp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [etp_pkg::QUEUE_CW-1:0] count_ff, count_in;
   etp_pkg::event_type ev_new;
   logic push_ok;
   logic pop_ok;

   always_comb begin
      ev_new.is_exit = (req_data.kind == etp_pkg::KIND_EXIT);
      ev_new.func_id = req_data.func_id;
      ev_new.base_time = {1'b0, req_data.timestamp} + 33'(ev_new.is_exit);
      ev_new.last_event = req_data.last_event;
   end

   assign req_full = (count_ff == etp_pkg::QUEUE_CW'(etp_pkg::QUEUE_DEPTH));
   assign ev_valid = (count_ff != '0);
   assign ev_data = queue_ff[rd_ptr_ff];
   assign push_ok = req_push && !req_full;
   assign pop_ok = ev_pop && ev_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == etp_pkg::QUEUE_AW'(etp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == etp_pkg::QUEUE_AW'(etp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= ev_new;
      end
   end

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Event queue count did not follow an accepted transaction.");

endmodule

@@ sv/etp_back.sv @@
module etp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   output logic                ev_pop,
   input  etp_pkg::event_type  ev_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output etp_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_data
);

   typedef enum logic [1:0] {
      ST_EXEC,
      ST_CREDIT,
      ST_DUMP
   } state_type;

   localparam int ENTRY_W = $bits(etp_pkg::stack_entry_type);

   state_type state_ff, state_in;
   logic [etp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [3:0] top_id_ff, top_id_in;
   logic [31:0] top_start_ff, top_start_in;
   logic err_ff, err_in;
   logic credit_en_ff, credit_en_in;
   logic [etp_pkg::TOT_IW-1:0] credit_id_ff, credit_id_in;
   logic [32:0] amount_ff, amount_in;
   logic pop_load_ff, pop_load_in;
   logic [31:0] new_start_ff, new_start_in;
   logic last_ff, last_in;
   logic [3:0] idx_ff, idx_in;
   logic [31:0] totals_ff [etp_pkg::NUM_FUNCS];
   logic [31:0] totals_in [etp_pkg::NUM_FUNCS];
   logic out_valid_ff, out_valid_in;
   etp_pkg::rsp_type out_data_ff, out_data_in;
   logic [4:0] fcount_ff;

   logic ram_wr_en;
   logic [etp_pkg::STACK_AW-1:0] ram_wr_addr;
   etp_pkg::stack_entry_type ram_wr_data;
   logic ram_rd_en;
   logic [etp_pkg::STACK_AW-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_raw;
   etp_pkg::stack_entry_type ram_rd_data;

   logic [33:0] diff;
   logic [32:0] span;
   logic [etp_pkg::TOT_IW-1:0] tot_raddr;
   logic [31:0] tot_rdata;
   logic [33:0] sum;
   logic [4:0] dump_n;
   logic dump_beat;
   logic dump_final;

   etp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(etp_pkg::STACK_DEPTH)
   ) u_stack (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_raw)
   );

   assign ram_rd_data = etp_pkg::stack_entry_type'(ram_rd_raw);
   assign csr_ready = 1'b1;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_data_ff;

   // A function count of zero dumps one total; a large one is capped.
   always_comb begin
      if (fcount_ff == '0) begin
         dump_n = 5'd1;
      end else if (fcount_ff > 5'(etp_pkg::DUMP_LIMIT)) begin
         dump_n = 5'(etp_pkg::DUMP_LIMIT);
      end else begin
         dump_n = fcount_ff;
      end
   end

   assign tot_raddr = (state_ff == ST_DUMP) ? etp_pkg::TOT_IW'(idx_ff) : credit_id_ff;
   assign tot_rdata = totals_ff[tot_raddr];
   assign sum = {2'b00, tot_rdata} + {1'b0, amount_ff};
   assign diff = {1'b0, ev_data.base_time} - {2'b00, top_start_ff};
   assign span = (diff[33] || (diff[32:0] == '0)) ? '0 : diff[32:0];
   assign dump_beat = (state_ff == ST_DUMP) && (!out_valid_ff || rsp_pop);
   assign dump_final = ({1'b0, idx_ff} == dump_n - 5'd1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      top_id_in = top_id_ff;
      top_start_in = top_start_ff;
      err_in = err_ff;
      credit_en_in = credit_en_ff;
      credit_id_in = credit_id_ff;
      amount_in = amount_ff;
      pop_load_in = pop_load_ff;
      new_start_in = new_start_ff;
      last_in = last_ff;
      idx_in = idx_ff;
      totals_in = totals_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in = out_data_ff;
      ev_pop = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = '0;
      ram_rd_en = 1'b0;
      ram_rd_addr = '0;

      unique case (state_ff)
         ST_EXEC: begin
            if (ev_valid) begin
               ev_pop = 1'b1;
               last_in = ev_data.last_event;
               amount_in = span;
               credit_en_in = 1'b0;
               pop_load_in = 1'b0;
               if (!ev_data.is_exit) begin
                  // The running caller is credited even when the push is dropped.
                  credit_en_in = (count_ff != '0) && (int'(top_id_ff) < etp_pkg::NUM_FUNCS);
                  credit_id_in = etp_pkg::TOT_IW'(top_id_ff);
                  if (count_ff == etp_pkg::COUNT_W'(etp_pkg::STACK_DEPTH)) begin
                     err_in = 1'b1;
                  end else begin
                     if (count_ff != '0) begin
                        ram_wr_en = 1'b1;
                        ram_wr_addr = etp_pkg::STACK_AW'(count_ff - 1'b1);
                        ram_wr_data.id = top_id_ff;
                        ram_wr_data.start = top_start_ff;
                     end
                     top_id_in = ev_data.func_id;
                     top_start_in = ev_data.base_time[31:0];
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  if (count_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     credit_en_in = (int'(ev_data.func_id) < etp_pkg::NUM_FUNCS);
                     credit_id_in = etp_pkg::TOT_IW'(ev_data.func_id);
                     count_in = count_ff - 1'b1;
                     new_start_in = ev_data.base_time[32] ? '1 : ev_data.base_time[31:0];
                     // The entry below the top comes back from memory next cycle.
                     if (count_ff > etp_pkg::COUNT_W'(1)) begin
                        ram_rd_en = 1'b1;
                        ram_rd_addr = etp_pkg::STACK_AW'(count_ff - 2'd2);
                        pop_load_in = 1'b1;
                     end
                  end
               end
               state_in = ST_CREDIT;
            end
         end
         ST_CREDIT: begin
            if (credit_en_ff) begin
               totals_in[credit_id_ff] = (sum[33:32] != 2'b00) ? '1 : sum[31:0];
            end
            if (pop_load_ff) begin
               top_id_in = ram_rd_data.id;
               top_start_in = new_start_ff;
            end
            idx_in = '0;
            state_in = last_ff ? ST_DUMP : ST_EXEC;
         end
         ST_DUMP: begin
            if (dump_beat) begin
               out_valid_in = 1'b1;
               out_data_in.result_id = idx_ff;
               out_data_in.total_time = tot_rdata;
               out_data_in.malformed = err_ff;
               out_data_in.last = dump_final;
               if (dump_final) begin
                  for (int i = 0; i < etp_pkg::NUM_FUNCS; i++) begin
                     totals_in[i] = '0;
                  end
                  count_in = '0;
                  err_in = 1'b0;
                  state_in = ST_EXEC;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EXEC;
         count_ff <= '0;
         err_ff <= 1'b0;
         credit_en_ff <= 1'b0;
         pop_load_ff <= 1'b0;
         last_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
         fcount_ff <= etp_pkg::FCOUNT_RESET;
         for (int i = 0; i < etp_pkg::NUM_FUNCS; i++) begin
            totals_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff <= err_in;
         credit_en_ff <= credit_en_in;
         pop_load_ff <= pop_load_in;
         last_ff <= last_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
         totals_ff <= totals_in;
         if (csr_valid && csr_ready) begin
            fcount_ff <= csr_data;
         end
      end
      top_id_ff <= top_id_in;
      top_start_ff <= top_start_in;
      credit_id_ff <= credit_id_in;
      amount_ff <= amount_in;
      new_start_ff <= new_start_in;
      out_data_ff <= out_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= etp_pkg::COUNT_W'(etp_pkg::STACK_DEPTH))
      else $error("Stack count exceeds the stack depth.");

   a_pop_follows_read: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == ST_CREDIT) && pop_load_ff)
      else $error("Stack read was not followed by a top reload.");

   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      (dump_beat && dump_final) |=> (count_ff == '0) && !err_ff && (state_ff == ST_EXEC))
      else $error("State was not cleared after the last total.");

   a_rsp_from_dump: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DUMP))
      else $error("A result appeared outside the totals dump.");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int IDLE_TAIL = 40;
   localparam int HOLD_AT = 90;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   etp_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   etp_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_data = '0;

   // Events waiting to be offered, and totals the block still owes us.
   etp_pkg::req_type pending_events[$];
   etp_pkg::rsp_type expected_totals[$];
   etp_pkg::rsp_type oldest_total;

   // Shadow of the profiler state.
   logic [3:0] call_ids [etp_pkg::STACK_DEPTH];
   logic [31:0] call_starts [etp_pkg::STACK_DEPTH];
   int call_depth = 0;
   logic [31:0] func_totals [etp_pkg::NUM_FUNCS] = '{default: '0};
   logic log_malformed = 1'b0;
   logic [4:0] function_count = etp_pkg::FCOUNT_RESET;

   logic [31:0] stamp_now = '0;
   bit idling_on = 1'b1;
   int send_gap = 0;
   int pop_gap = 0;
   int events_accepted = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;
   int cycle_count = 0;
   int failures = 0;

   exclusive_time_profiler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void credit_time(logic [3:0] id, logic [32:0] later,
                                       logic [31:0] earlier);
      logic [32:0] amount;
      logic [33:0] sum;
      amount = (later > {1'b0, earlier}) ? later - {1'b0, earlier} : 33'd0;
      if (int'(id) < etp_pkg::NUM_FUNCS) begin
         sum = 34'(func_totals[id]) + 34'(amount);
         func_totals[id] = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
   endfunction

   // Applies one event to the shadow state and, on the last event of a log,
   // queues the totals dump.
   function automatic void account_event(etp_pkg::req_type ev);
      etp_pkg::rsp_type total;
      int n;
      if (ev.kind == etp_pkg::KIND_ENTER) begin
         if (call_depth > 0)
            credit_time(call_ids[call_depth - 1], {1'b0, ev.timestamp},
                        call_starts[call_depth - 1]);
         if (call_depth >= etp_pkg::STACK_DEPTH) begin
            log_malformed = 1'b1;
         end else begin
            call_ids[call_depth] = ev.func_id;
            call_starts[call_depth] = ev.timestamp;
            call_depth++;
         end
      end else if (call_depth == 0) begin
         log_malformed = 1'b1;
      end else begin
         call_depth--;
         credit_time(ev.func_id, {1'b0, ev.timestamp} + 33'd1, call_starts[call_depth]);
         if (call_depth > 0)
            call_starts[call_depth - 1] = (ev.timestamp == 32'hFFFF_FFFF) ?
                                          32'hFFFF_FFFF : ev.timestamp + 32'd1;
      end
      if (ev.last_event) begin
         n = int'(function_count);
         if (n < 1) n = 1;
         if (n > etp_pkg::DUMP_LIMIT) n = etp_pkg::DUMP_LIMIT;
         for (int i = 0; i < n; i++) begin
            total.result_id = 4'(i);
            total.total_time = func_totals[i];
            total.malformed = log_malformed;
            total.last = (i == n - 1);
            expected_totals.insert(expected_totals.size(), total);
         end
         func_totals = '{default: '0};
         call_depth = 0;
         log_malformed = 1'b0;
      end
   endfunction

   function automatic void note_failure(string what);
      failures++;
      if (failures <= 10) $display("%s", what);
   endfunction

   function automatic logic [31:0] next_stamp();
      case ($urandom_range(0, 15))
         0: stamp_now = $urandom;
         1: stamp_now = stamp_now + $urandom_range(1000, 1 << 30);
         default: stamp_now = stamp_now + $urandom_range(0, 25);
      endcase
      return stamp_now;
   endfunction

   task automatic queue_event(logic kind, logic [3:0] id, logic [31:0] stamp, logic last_ev);
      etp_pkg::req_type ev;
      ev.kind = kind;
      ev.func_id = id;
      ev.timestamp = stamp;
      ev.last_event = last_ev;
      pending_events.insert(pending_events.size(), ev);
   endtask

   // One log of nested calls. A broken log sometimes flips enter and exit and
   // names the wrong function on exit; a deep log overruns the call stack.
   task automatic queue_log(int length, bit broken, bit deep);
      logic [3:0] open_calls[$];
      logic [3:0] id;
      bit do_enter;
      if ($urandom_range(0, 5) == 0)
         stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else if ($urandom_range(0, 3) == 0)
         stamp_now = $urandom_range(0, 50);
      for (int k = 0; k < length; k++) begin
         if (deep)
            do_enter = (k < etp_pkg::STACK_DEPTH + 4);
         else
            do_enter = (open_calls.size() == 0) ||
                       (open_calls.size() < length - k - 1 && open_calls.size() < 8 &&
                        $urandom_range(0, 1) == 0);
         if (broken && $urandom_range(0, 3) == 0) do_enter = !do_enter;
         if (do_enter) begin
            id = 4'($urandom_range(0, 15));
            open_calls.insert(open_calls.size(), id);
         end else begin
            id = (open_calls.size() != 0) ? open_calls.pop_back() : 4'($urandom);
            if (broken && $urandom_range(0, 3) == 0) id = 4'($urandom);
         end
         queue_event(do_enter ? etp_pkg::KIND_ENTER : etp_pkg::KIND_EXIT, id, next_stamp(),
                     k == length - 1);
      end
   endtask

   task automatic queue_random_items(int budget);
      int added;
      int len;
      added = 0;
      while (added < budget) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_event(1'($urandom), 4'($urandom), $urandom, $urandom_range(0, 3) == 0);
               added++;
            end
            1: begin
               len = $urandom_range(1, 10);
               queue_log(len, 1'b1, 1'b0);
               added += len;
            end
            default: begin
               len = $urandom_range(2, 12);
               queue_log(len, 1'b0, 1'b0);
               added += len;
            end
         endcase
      end
   endtask

   // Waits until every event is in and every total is out, then lets the
   // block finish any event that produces no result.
   task automatic settle();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_push || expected_totals.size() != 0);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   task automatic write_function_count(logic [4:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      function_count = value;
      csr_valid <= 1'b0;
   endtask

   // Event driver.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_push && !req_full) begin
            account_event(req_data);
            events_accepted <= events_accepted + 1;
         end
         if (!(req_push && req_full)) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_push <= 1'b0;
            end else if (pending_events.size() != 0) begin
               req_data <= pending_events.pop_front();
               req_push <= 1'b1;
               if (idling_on && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 11);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // One long hold-off on the result side, so the block backs up and
   // raises req_full while events keep coming.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && events_accepted >= HOLD_AT) begin
         hold_cycles <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_totals.size() == 0) begin
               note_failure($sformatf("unexpected total: id %0d time %0d malformed %0b last %0b",
                                      rsp_data.result_id, rsp_data.total_time,
                                      rsp_data.malformed, rsp_data.last));
            end else begin
               oldest_total = expected_totals.pop_front();
               if (rsp_data.result_id !== oldest_total.result_id ||
                   rsp_data.total_time !== oldest_total.total_time ||
                   rsp_data.malformed !== oldest_total.malformed ||
                   rsp_data.last !== oldest_total.last)
                  note_failure($sformatf({"total mismatch: expected id %0d time %0d ",
                                          "malformed %0b last %0b, got id %0d time %0d ",
                                          "malformed %0b last %0b"},
                                         oldest_total.result_id, oldest_total.total_time,
                                         oldest_total.malformed, oldest_total.last,
                                         rsp_data.result_id, rsp_data.total_time,
                                         rsp_data.malformed, rsp_data.last));
            end
         end
         if (hold_cycles != 0) begin
            rsp_pop <= 1'b0;
         end else if (pop_gap != 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (idling_on && $urandom_range(0, 7) == 0)
               pop_gap <= $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Extreme timestamps, saturation of a total and of the restart time.
      queue_event(etp_pkg::KIND_ENTER, 4'd0, 32'd0, 1'b0);
      queue_event(etp_pkg::KIND_ENTER, 4'd15, 32'hFFFF_FFFF, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd15, 32'hFFFF_FFFF, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd0, 32'hFFFF_FFFF, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd3, 32'd5, 1'b1);
      // Timestamps running backwards, and an exit naming another function.
      queue_event(etp_pkg::KIND_ENTER, 4'd7, 32'd1000, 1'b0);
      queue_event(etp_pkg::KIND_ENTER, 4'd8, 32'd500, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd8, 32'd400, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd9, 32'd2000, 1'b1);
      // Exit on an empty stack, then a dump with a call still open.
      queue_event(etp_pkg::KIND_EXIT, 4'd12, 32'd0, 1'b0);
      queue_event(etp_pkg::KIND_ENTER, 4'd1, 32'd10, 1'b1);
      queue_event(etp_pkg::KIND_ENTER, 4'd2, 32'hAAAA_5555, 1'b0);
      queue_event(etp_pkg::KIND_ENTER, 4'd4, 32'hAAAA_5560, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd4, 32'hAAAA_5570, 1'b0);
      queue_event(etp_pkg::KIND_EXIT, 4'd2, 32'hAAAA_5580, 1'b1);
      settle();

      write_function_count(5'd1);
      queue_random_items(50);
      settle();

      write_function_count(5'd31);
      queue_log(etp_pkg::STACK_DEPTH + 16, 1'b0, 1'b1);
      queue_random_items(55);
      settle();

      write_function_count(5'd0);
      queue_random_items(50);
      settle();

      write_function_count(5'd16);
      queue_random_items(60);
      settle();

      write_function_count(5'($urandom_range(2, 15)));
      idling_on = 1'b0;
      queue_random_items(60);
      settle();

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/etp_pkg.sv
sv/etp_ram.sv
sv/etp_front.sv
sv/etp_back.sv
sv/exclusive_time_profiler.sv
tb/testbench.sv
